// ----- rtl/sprl_pkg.sv -----
// Shared types and constants for the sprite RLE line decoder.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package sprl_pkg;

  // Configuration register indexes.
  localparam logic [2:0] CfgStartX      = 3'd0;
  localparam logic [2:0] CfgEndX        = 3'd1;
  localparam logic [2:0] CfgCanvasWidth = 3'd2;
  localparam logic [2:0] CfgRemapEnable = 3'd3;
  localparam logic [2:0] CfgRemapColors = 3'd4;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 64;

  // Code byte flags.
  localparam logic [7:0] SkipFlag   = 8'h80;
  localparam logic [7:0] RepeatFlag = 8'h40;

  // Cursor saturates here.
  localparam logic signed [13:0] XMax = 14'sd8191;

  // Depth of the run queue between parser and pixel generator.
  localparam int unsigned RunQDepth = 2;

  typedef enum logic [2:0] {
    PH_CTRL   = 3'b001,
    PH_REPCOL = 3'b010,
    PH_LIT    = 3'b100
  } phase_e;

  typedef struct packed {
    logic signed [13:0] start_x;
    logic [12:0]        end_x;
    logic [12:0]        canvas_width;
    logic               remap_enable;
    logic [63:0]        remap_colors;
  } cfg_t;

  // One run of visible pixels: first x, pixel count (1..63) and color.
  typedef struct packed {
    logic [12:0] x;
    logic [5:0]  count;
    logic [7:0]  color;
  } run_t;

  function automatic logic signed [13:0] sat_add(input logic signed [13:0] c,
                                                 input logic [6:0] n);
    logic signed [14:0] s;
    s = {c[13], c} + $signed({8'b0, n});
    if (s > $signed({XMax[13], XMax})) begin
      sat_add = XMax;
    end else begin
      sat_add = s[13:0];
    end
  endfunction

  function automatic logic reached_end(input logic signed [13:0] c,
                                       input logic [12:0] end_x);
    reached_end = ($signed({c[13], c}) >= $signed({2'b00, end_x}));
  endfunction

endpackage

`default_nettype wire

// ----- rtl/sprite_rle_line_decoder_top.sv -----
// Top level of the sprite RLE line decoder: configuration registers, byte
// parser, run queue and pixel generator. Depends on sprl_pkg and submodules.
//
//   Port group   Dir  Handshake            Payload
//   config       in   cfg_we_i             cfg_idx_i, cfg_data_i
//   code bytes   in   in_valid_i/ready_o   code_byte_i, line_start_i
//   pixels       out  out_valid_o/ready_i  pixel_x_o, color_o, last_o
//
// The parser takes one byte per cycle while the two-entry run queue has room.
// The pixel generator emits one pixel per cycle unless the output stalls, so a
// run of n visible pixels gives it n beats; the input stalls once the queue is
// full behind it. A pixel passes the run queue, run registers and output beat.
// Reset clears the parser to the idle state, waiting for a line start.
// A stalled output beat holds while the parser keeps filling the queue.
`default_nettype none

module sprite_rle_line_decoder_top #(
  parameter int unsigned MAX_WIDTH = 4096
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [sprl_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  wire logic [sprl_pkg::CfgDataW-1:0]  cfg_data_i,
  input  wire logic                           in_valid_i,
  output logic                                in_ready_o,
  input  wire logic [7:0]                     code_byte_i,
  input  wire logic                           line_start_i,
  output logic                                out_valid_o,
  input  wire logic                           out_ready_i,
  output logic [11:0]                         pixel_x_o,
  output logic [7:0]                          color_o,
  output logic                                last_o
);
  import sprl_pkg::*;

  cfg_t cfg_q;
  logic push, full, pop, head_valid;
  run_t push_data, head;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgStartX:      cfg_q.start_x      <= cfg_data_i[13:0];
        CfgEndX:        cfg_q.end_x        <= cfg_data_i[12:0];
        CfgCanvasWidth: cfg_q.canvas_width <= cfg_data_i[12:0];
        CfgRemapEnable: cfg_q.remap_enable <= cfg_data_i[0];
        CfgRemapColors: cfg_q.remap_colors <= cfg_data_i;
        default: ;
      endcase
    end
  end

  sprl_front #(
    .MAX_WIDTH(MAX_WIDTH)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .code_byte_i  (code_byte_i),
    .line_start_i (line_start_i),
    .push_o       (push),
    .push_data_o  (push_data),
    .full_i       (full)
  );

  sprl_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_data_i  (push_data),
    .full_o       (full),
    .pop_i        (pop),
    .head_valid_o (head_valid),
    .head_o       (head)
  );

  sprl_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_i       (head),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .pixel_x_o    (pixel_x_o),
    .color_o      (color_o),
    .last_o       (last_o)
  );

endmodule

`default_nettype wire

// ----- rtl/sprl_fifo.sv -----
// Short run queue between the byte parser and the pixel generator.
// Depends on sprl_pkg for the run entry type and the depth.
`default_nettype none

module sprl_fifo (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           push_i,
  input  sprl_pkg::run_t      push_data_i,
  output logic                full_o,
  input  wire logic           pop_i,
  output logic                head_valid_o,
  output sprl_pkg::run_t      head_o
);
  import sprl_pkg::*;

  localparam int unsigned PtrW = (RunQDepth > 1) ? $clog2(RunQDepth) : 1;
  localparam int unsigned CntW = $clog2(RunQDepth + 1);

  run_t            mem_q [RunQDepth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign full_o       = (cnt_q == CntW'(RunQDepth));
  assign head_valid_o = (cnt_q != '0);
  assign head_o       = mem_q[rd_ptr_q];
  assign do_push      = push_i & ~full_o;
  assign do_pop       = pop_i & head_valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(RunQDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(RunQDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/sprl_front.sv -----
// Byte parser: tracks parse phase, run count and cursor, and turns each
// accepted code byte into at most one run of visible pixels. Uses sprl_pkg.
`default_nettype none

module sprl_front #(
  parameter int unsigned MAX_WIDTH = 4096
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  sprl_pkg::cfg_t      cfg_i,
  input  wire logic           in_valid_i,
  output logic                in_ready_o,
  input  wire logic [7:0]     code_byte_i,
  input  wire logic           line_start_i,
  output logic                push_o,
  output sprl_pkg::run_t      push_data_o,
  input  wire logic           full_i
);
  import sprl_pkg::*;

  localparam logic [16:0] MaxW = 17'(MAX_WIDTH);

  phase_e             phase_q, phase_d;
  logic [5:0]         run_q, run_d;
  logic signed [13:0] cursor_q, cursor_d;
  logic               done_q, done_d;

  logic               accept;
  logic [5:0]         emit_n;
  logic signed [13:0] emit_c;
  logic [14:0]        neg_c;
  logic [12:0]        cw_eff;
  logic [7:0]         color;

  // Clip a run so it ends at the canvas width, unless already past it.
  function automatic logic [5:0] clip(input logic [5:0] n,
                                      input logic signed [13:0] c,
                                      input logic [12:0] cw);
    logic signed [15:0] room;
    room = $signed({3'b000, cw}) - $signed({{2{c[13]}}, c});
    clip = n;
    if (room >= 16'sd0 && $signed({10'b0, n}) > room) begin
      clip = room[5:0];
    end
  endfunction

  assign in_ready_o = ~full_i;
  assign accept     = in_valid_i & in_ready_o;
  assign cw_eff     = ({4'b0, cfg_i.canvas_width} < MaxW) ? cfg_i.canvas_width : MaxW[12:0];

  always_comb begin
    phase_d  = phase_q;
    run_d    = run_q;
    cursor_d = cursor_q;
    done_d   = done_q;
    emit_n   = '0;

    if (line_start_i) begin
      cursor_d = cfg_i.start_x;
      phase_d  = PH_CTRL;
      run_d    = '0;
      done_d   = reached_end(cfg_i.start_x, cfg_i.end_x);
    end
    emit_c = cursor_d;

    if (!done_d) begin
      case (phase_d)
        PH_REPCOL: begin
          emit_n   = run_d;
          cursor_d = sat_add(cursor_d, {1'b0, run_d});
          run_d    = '0;
          phase_d  = PH_CTRL;
          done_d   = reached_end(cursor_d, cfg_i.end_x);
        end
        PH_LIT: begin
          emit_n   = 6'd1;
          cursor_d = sat_add(cursor_d, 7'd1);
          run_d    = run_d - 6'd1;
          if (run_d == '0) begin
            phase_d = PH_CTRL;
            done_d  = reached_end(cursor_d, cfg_i.end_x);
          end
        end
        default: begin
          if ((code_byte_i & SkipFlag) != '0) begin
            cursor_d = sat_add(cursor_d, code_byte_i[6:0]);
            phase_d  = PH_CTRL;
            done_d   = reached_end(cursor_d, cfg_i.end_x);
          end else if ((code_byte_i & RepeatFlag) != '0) begin
            run_d   = clip(code_byte_i[5:0], cursor_d, cw_eff);
            phase_d = PH_REPCOL;
          end else begin
            run_d = clip(code_byte_i[5:0], cursor_d, cw_eff);
            if (run_d == '0) begin
              phase_d = PH_CTRL;
              done_d  = reached_end(cursor_d, cfg_i.end_x);
            end else begin
              phase_d = PH_LIT;
            end
          end
        end
      endcase
    end
  end

  // When remap is enabled, team colors 8..15 come from the remap table.
  always_comb begin
    color = code_byte_i;
    if (cfg_i.remap_enable && code_byte_i[7:3] == 5'b00001) begin
      color = cfg_i.remap_colors[{code_byte_i[2:0], 3'b000} +: 8];
    end
  end

  // Pixels left of the canvas are dropped here, so only visible ones queue.
  assign neg_c = -{emit_c[13], emit_c};

  always_comb begin
    push_data_o.color = color;
    if (emit_c[13]) begin
      push_data_o.x = '0;
      if (neg_c >= {9'b0, emit_n}) begin
        push_data_o.count = '0;
      end else begin
        push_data_o.count = emit_n - neg_c[5:0];
      end
    end else begin
      push_data_o.x     = emit_c[12:0];
      push_data_o.count = emit_n;
    end
  end

  assign push_o = accept & (push_data_o.count != '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_CTRL;
      run_q    <= '0;
      cursor_q <= '0;
      done_q   <= 1'b1;
    end else if (accept) begin
      phase_q  <= phase_d;
      run_q    <= run_d;
      cursor_q <= cursor_d;
      done_q   <= done_d;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/sprl_back.sv -----
// Pixel generator: takes runs from the queue and emits one pixel per cycle
// through a registered output beat while it is not stalled. Uses sprl_pkg.
`default_nettype none

module sprl_back (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           head_valid_i,
  input  sprl_pkg::run_t      head_i,
  output logic                pop_o,
  output logic                out_valid_o,
  input  wire logic           out_ready_i,
  output logic [11:0]         pixel_x_o,
  output logic [7:0]          color_o,
  output logic                last_o
);
  import sprl_pkg::*;

  logic        busy_q;
  logic [12:0] x_q;
  logic [5:0]  cnt_q;
  logic [7:0]  col_q;
  logic        out_valid_q;
  logic [11:0] px_q;
  logic [7:0]  ocol_q;
  logic        last_q;

  logic        slot_free, step, final_px;

  assign slot_free = ~out_valid_q | out_ready_i;
  assign step      = busy_q & slot_free;
  assign final_px  = (cnt_q == 6'd1);
  assign pop_o     = head_valid_i & (~busy_q | (step & final_px));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (pop_o) begin
        busy_q <= 1'b1;
      end else if (step && final_px) begin
        busy_q <= 1'b0;
      end
      if (step) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // The cursor holds at its limit, so a run past it repeats the last x.
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      x_q   <= head_i.x;
      cnt_q <= head_i.count;
      col_q <= head_i.color;
    end else if (step) begin
      x_q   <= (x_q == XMax[12:0]) ? x_q : x_q + 13'd1;
      cnt_q <= cnt_q - 6'd1;
    end
    if (step) begin
      px_q   <= x_q[11:0];
      ocol_q <= col_q;
      last_q <= final_px;
    end
  end

  assign out_valid_o = out_valid_q;
  assign pixel_x_o   = px_q;
  assign color_o     = ocol_q;
  assign last_o      = last_q;

endmodule

`default_nettype wire

// ----- bench/testbench.sv -----
`timescale 1ns / 1ps
// Self-checking bench for sprite_rle_line_decoder_top: drives coded sprite lines,
// decodes them again in a behavioral predictor and compares every pixel beat.
// Depends on sprl_pkg and the decoder RTL.

module testbench;
  import sprl_pkg::*;

  localparam int unsigned MaxWidth    = 4096;
  localparam int unsigned GapMax      = 18;
  localparam int unsigned RandItems   = 75;
  localparam int unsigned DrainCycles = 8;

  // Table rows with this pixel count take their expectation from the predictor.
  localparam logic signed [7:0] Predicted = -8'sd1;

  typedef struct packed {
    logic [11:0] x;
    logic [7:0]  color;
    logic        last;
  } pixel_t;

  typedef struct packed {
    logic                is_cfg;
    logic [CfgIdxW-1:0]  idx;
    logic [CfgDataW-1:0] data;
    logic [7:0]          code;
    logic                ls;
    logic signed [7:0]   npix;
    logic [11:0]         x0;
    logic [7:0]          color;
  } step_row_t;

  localparam int NumRows = 39;
  localparam step_row_t DirectedSteps [NumRows] = '{
    '{1'b1, CfgStartX,      64'd0,    8'h00, 1'b0, Predicted, 12'd0, 8'h00},
    '{1'b1, CfgEndX,        64'd4096, 8'h00, 1'b0, Predicted, 12'd0, 8'h00},
    '{1'b1, CfgCanvasWidth, 64'd4096, 8'h00, 1'b0, Predicted, 12'd0, 8'h00},
    // Out of reset the decoder waits for a line start.
    '{1'b0, CfgStartX, 64'd0, 8'h45, 1'b0, 8'sd0,  12'd0, 8'h00},
    '{1'b0, CfgStartX, 64'd0, 8'h43, 1'b1, 8'sd0,  12'd0, 8'h00},
    '{1'b0, CfgStartX, 64'd0, 8'h07, 1'b0, 8'sd3,  12'd0, 8'h07},
    '{1'b0, CfgStartX, 64'd0, 8'h82, 1'b0, 8'sd0,  12'd0, 8'h00},
    '{1'b0, CfgStartX, 64'd0, 8'h02, 1'b0, 8'sd0,  12'd0, 8'h00},
    '{1'b0, CfgStartX, 64'd0, 8'hFF, 1'b0, 8'sd1,  12'd5, 8'hFF},
    '{1'b0, CfgStartX, 64'd0, 8'h00, 1'b0, 8'sd1,  12'd6, 8'h00},
    // Zero counts: literal, skip, and a repeat that still eats its color.
    '{1'b0, CfgStartX, 64'd0, 8'h00, 1'b0, 8'sd0,  12'd0, 8'h00},
    '{1'b0, CfgStartX, 64'd0, 8'h80, 1'b0, 8'sd0,  12'd0, 8'h00},
    '{1'b0, CfgStartX, 64'd0, 8'h40, 1'b0, 8'sd0,  12'd0, 8'h00},
    '{1'b0, CfgStartX, 64'd0, 8'h33, 1'b0, 8'sd0,  12'd0, 8'h00},
    '{1'b0, CfgStartX, 64'd0, 8'h7F, 1'b0, 8'sd0,  12'd0, 8'h00},
    '{1'b0, CfgStartX, 64'd0, 8'h0C, 1'b0, 8'sd63, 12'd7, 8'h0C},
    '{1'b1, CfgRemapColors, 64'h8877_6655_4433_2211, 8'h00, 1'b0, Predicted, 12'd0, 8'h00},
    '{1'b1, CfgRemapEnable, 64'd1,    8'h00, 1'b0, Predicted, 12'd0, 8'h00},
    '{1'b1, CfgStartX,      64'h3FFD, 8'h00, 1'b0, Predicted, 12'd0, 8'h00},
    // Negative start: the first three pixels are consumed but hidden.
    '{1'b0, CfgStartX, 64'd0, 8'h44, 1'b1, 8'sd0,  12'd0, 8'h00},
    '{1'b0, CfgStartX, 64'd0, 8'h0F, 1'b0, 8'sd1,  12'd0, 8'h88},
    '{1'b0, CfgStartX, 64'd0, 8'h01, 1'b0, 8'sd0,  12'd0, 8'h00},
    '{1'b0, CfgStartX, 64'd0, 8'h08, 1'b0, 8'sd1,  12'd1, 8'h11},
    '{1'b1, CfgCanvasWidth, 64'd5,    8'h00, 1'b0, Predicted, 12'd0, 8'h00},
    // Repeat of ten clipped to the three pixels left before the canvas edge.
    '{1'b0, CfgStartX, 64'd0, 8'h4A, 1'b0, 8'sd0,  12'd0, 8'h00},
    '{1'b0, CfgStartX, 64'd0, 8'h09, 1'b0, 8'sd3,  12'd2, 8'h22},
    '{1'b0, CfgStartX, 64'd0, 8'h05, 1'b0, 8'sd0,  12'd0, 8'h00},
    // Past the canvas edge no clipping applies at all.
    '{1'b0, CfgStartX, 64'd0, 8'h86, 1'b0, 8'sd0,  12'd0, 8'h00},
    '{1'b0, CfgStartX, 64'd0, 8'h41, 1'b0, 8'sd0,  12'd0, 8'h00},
    '{1'b0, CfgStartX, 64'd0, 8'h10, 1'b0, 8'sd1,  12'd11, 8'h10},
    '{1'b1, CfgStartX,      64'd8100, 8'h00, 1'b0, Predicted, 12'd0, 8'h00},
    '{1'b1, CfgEndX,        64'd8191, 8'h00, 1'b0, Predicted, 12'd0, 8'h00},
    '{1'b0, CfgStartX, 64'd0, 8'h41, 1'b1, Predicted, 12'd0, 8'h00},
    '{1'b0, CfgStartX, 64'd0, 8'h05, 1'b0, Predicted, 12'd0, 8'h00},
    // The skip saturates the cursor at its maximum, which ends the line.
    '{1'b0, CfgStartX, 64'd0, 8'hFF, 1'b0, 8'sd0,  12'd0, 8'h00},
    '{1'b0, CfgStartX, 64'd0, 8'h41, 1'b0, 8'sd0,  12'd0, 8'h00},
    '{1'b1, CfgStartX,      64'd10,   8'h00, 1'b0, Predicted, 12'd0, 8'h00},
    '{1'b1, CfgEndX,        64'd10,   8'h00, 1'b0, Predicted, 12'd0, 8'h00},
    // Start at the end limit: even the line start byte is dropped.
    '{1'b0, CfgStartX, 64'd0, 8'h41, 1'b1, 8'sd0,  12'd0, 8'h00}
  };

  logic                clk_i        = 1'b0;
  logic                rst_ni       = 1'b0;
  logic                cfg_we_i     = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i    = '0;
  logic [CfgDataW-1:0] cfg_data_i   = '0;
  logic                in_valid_i   = 1'b0;
  logic [7:0]          code_byte_i  = 8'h00;
  logic                line_start_i = 1'b0;
  logic                out_ready_i  = 1'b0;
  logic                in_ready_o;
  logic                out_valid_o;
  logic [11:0]         pixel_x_o;
  logic [7:0]          color_o;
  logic                last_o;

  // Predictor copy of the registers and the line parser.
  logic signed [13:0] set_start_x  = '0;
  logic [12:0]        set_end_x    = '0;
  logic [12:0]        set_canvas   = '0;
  logic               set_remap    = 1'b0;
  logic [63:0]        set_colors   = '0;
  phase_e             dec_phase    = PH_CTRL;
  int                 run_left     = 0;
  int                 cur_x        = 0;
  bit                 dec_done     = 1'b1;

  pixel_t step_pixels[$];
  pixel_t pending_pixels[$];

  int errors      = 0;
  int rx_hold     = 0;
  int random_sent = 0;
  bit tx_calm     = 1'b0;
  bit rx_calm     = 1'b0;

  sprite_rle_line_decoder_top DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .code_byte_i  (code_byte_i),
    .line_start_i (line_start_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .pixel_x_o    (pixel_x_o),
    .color_o      (color_o),
    .last_o       (last_o)
  );

  always #2 clk_i = ~clk_i;

  function automatic void apply_setting(input logic [CfgIdxW-1:0] idx,
                                        input logic [CfgDataW-1:0] data);
    case (idx)
      CfgStartX:      set_start_x = data[13:0];
      CfgEndX:        set_end_x   = data[12:0];
      CfgCanvasWidth: set_canvas  = data[12:0];
      CfgRemapEnable: set_remap   = data[0];
      CfgRemapColors: set_colors  = data;
      default: ;
    endcase
  endfunction

  function automatic int clip_run(input int n);
    int cw;
    int room;
    cw = (set_canvas < MaxWidth) ? int'(set_canvas) : MaxWidth;
    if (cur_x <= cw) begin
      room = cw - cur_x;
      if (n > room) n = room;
    end
    return n;
  endfunction

  function automatic logic [7:0] team_color(input logic [7:0] c);
    if (set_remap && c >= 8 && c <= 15) return set_colors[(int'(c) - 8) * 8 +: 8];
    return c;
  endfunction

  function automatic void put_pixel(input logic [7:0] c);
    if (cur_x >= 0) step_pixels.push_back('{x: 12'(cur_x), color: team_color(c), last: 1'b0});
    if (cur_x < int'(XMax)) cur_x++;
  endfunction

  function automatic void mark_end();
    if (cur_x >= int'(set_end_x)) dec_done = 1'b1;
  endfunction

  // Decodes one accepted byte into step_pixels and advances the parser.
  function automatic void decode_byte(input logic [7:0] b, input logic ls);
    step_pixels.delete();
    if (ls) begin
      cur_x     = int'(set_start_x);
      dec_phase = PH_CTRL;
      run_left  = 0;
      dec_done  = 1'b0;
      mark_end();
    end
    if (dec_done) return;
    if (dec_phase == PH_REPCOL) begin
      repeat (run_left) put_pixel(b);
      run_left  = 0;
      dec_phase = PH_CTRL;
      mark_end();
    end else if (dec_phase == PH_LIT) begin
      put_pixel(b);
      run_left = (run_left - 1) & 'hFF;
      if (run_left == 0) begin
        dec_phase = PH_CTRL;
        mark_end();
      end
    end else if ((b & SkipFlag) != 0) begin
      cur_x = cur_x + int'(b[6:0]);
      if (cur_x > int'(XMax)) cur_x = int'(XMax);
      dec_phase = PH_CTRL;
      mark_end();
    end else if ((b & RepeatFlag) != 0) begin
      run_left  = clip_run(int'(b[5:0]));
      dec_phase = PH_REPCOL;
    end else begin
      run_left = clip_run(int'(b));
      if (run_left == 0) begin
        dec_phase = PH_CTRL;
        mark_end();
      end else begin
        dec_phase = PH_LIT;
      end
    end
    if (step_pixels.size() > 0) step_pixels[step_pixels.size() - 1].last = 1'b1;
  endfunction

  function automatic void expect_predicted();
    foreach (step_pixels[i]) pending_pixels.push_back(step_pixels[i]);
  endfunction

  function automatic logic [7:0] pick_color();
    if ($urandom_range(0, 1) == 0) return 8'($urandom_range(8, 15));
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic report(input string what);
    errors++;
    $display("[%0t] mismatch: %s", $time, what);
  endtask

  task automatic check_pixel();
    pixel_t want;
    if (pending_pixels.size() == 0) begin
      report($sformatf("unexpected pixel x=%0d color=%02h last=%0b",
                       pixel_x_o, color_o, last_o));
      return;
    end
    want = pending_pixels.pop_front();
    if (pixel_x_o !== want.x)
      report($sformatf("pixel_x %0d, expected %0d", pixel_x_o, want.x));
    if (color_o !== want.color)
      report($sformatf("color %02h at x=%0d, expected %02h", color_o, want.x, want.color));
    if (last_o !== want.last)
      report($sformatf("last %0b at x=%0d, expected %0b", last_o, want.x, want.last));
  endtask

  // Pixel sink: one beat per accepted result, then a random stall.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      rx_hold = 0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        check_pixel();
        rx_hold = rx_calm ? 0 : $urandom_range(0, GapMax);
      end
      if (rx_hold > 0) begin
        rx_hold--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // Valid is left high after the beat so that a back-to-back byte needs no drop.
  task automatic send_byte(input logic [7:0] b, input logic ls);
    int gap;
    gap = tx_calm ? 0 : $urandom_range(0, GapMax);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    code_byte_i  <= b;
    line_start_i <= ls;
    do @(posedge clk_i); while (!in_ready_o);
    decode_byte(b, ls);
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    apply_setting(idx, data);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic send_random(input logic [7:0] b, input logic ls);
    send_byte(b, ls);
    expect_predicted();
    random_sent++;
    if ($urandom_range(0, 60) == 0) wait_idle();
  endtask

  // Mostly well-formed lines with random content; some raw noise bytes too.
  task automatic send_random_line();
    int   op;
    int   n;
    logic first;
    first = 1'b1;
    repeat ($urandom_range(1, 7)) begin
      op = $urandom_range(0, 9);
      if (op < 2) begin
        n = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 127) : $urandom_range(0, 12);
        send_random(SkipFlag | 8'(n), first);
      end else if (op < 6) begin
        n = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 63) : $urandom_range(0, 8);
        send_random(RepeatFlag | 8'(n), first);
        send_random(pick_color(), 1'b0);
      end else if (op < 9) begin
        n = $urandom_range(0, 5);
        send_random(8'(n), first);
        repeat (n) send_random(pick_color(), 1'b0);
      end else begin
        send_random(8'($urandom), first | ($urandom_range(0, 7) == 0));
      end
      first = 1'b0;
    end
  endtask

  task automatic random_setup(input int phase_no);
    int s;
    int ex;
    int cw;
    if (phase_no == 0) begin
      s = -4096; ex = 4096; cw = 4096;
    end else if (phase_no == 1) begin
      s = 4096; ex = 8191; cw = 8191;
    end else begin
      case ($urandom_range(0, 7))
        0:       s = -4096;
        1:       s = 4096;
        2:       s = $urandom_range(0, 8192) - 4096;
        default: s = $urandom_range(0, 340) - 40;
      endcase
      case ($urandom_range(0, 5))
        0:       ex = 0;
        1:       ex = 4096;
        2:       ex = 8191;
        default: ex = $urandom_range(100, 4096);
      endcase
      case ($urandom_range(0, 5))
        0:       cw = 0;
        1:       cw = 4096;
        2:       cw = 8191;
        default: cw = $urandom_range(16, 600);
      endcase
    end
    write_reg(CfgStartX, {50'd0, 14'(s)});
    write_reg(CfgEndX, 64'(ex));
    write_reg(CfgCanvasWidth, 64'(cw));
    write_reg(CfgRemapEnable, 64'($urandom_range(0, 1)));
    write_reg(CfgRemapColors, {$urandom, $urandom});
    tx_calm = ($urandom_range(0, 3) == 0);
    rx_calm = ($urandom_range(0, 3) == 0);
  endtask

  initial begin
    step_row_t row;
    bit        need_drain;
    int        phase_no;
    need_drain = 1'b0;
    phase_no   = 0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < NumRows; i++) begin
      row = DirectedSteps[i];
      if (row.is_cfg) begin
        if (need_drain) wait_idle();
        need_drain = 1'b0;
        write_reg(row.idx, row.data);
      end else begin
        send_byte(row.code, row.ls);
        if (row.npix == Predicted) begin
          expect_predicted();
        end else begin
          for (int k = 0; k < row.npix; k++)
            pending_pixels.push_back('{x: row.x0 + 12'(k), color: row.color,
                                       last: (k == row.npix - 1)});
        end
        need_drain = 1'b1;
      end
    end

    while (random_sent < RandItems) begin
      wait_idle();
      random_setup(phase_no);
      repeat ($urandom_range(1, 3)) send_random_line();
      phase_no++;
    end

    wait_idle();
    repeat (20) @(posedge clk_i);
    if (pending_pixels.size() != 0)
      report($sformatf("%0d pixels never arrived", pending_pixels.size()));
    if (errors == 0) begin
      $display("sprite_rle_line_decoder_top test passed");
    end else begin
      $display("sprite_rle_line_decoder_top test failed");
    end
    $finish;
  end

  initial begin
    #3_000_000;
    $display("sprite_rle_line_decoder_top test failed");
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/sprl_pkg.sv
rtl/sprl_fifo.sv
rtl/sprl_front.sv
rtl/sprl_back.sv
rtl/sprite_rle_line_decoder_top.sv
bench/testbench.sv
